FILE: hdl/toc_pkg.sv
// Shared types, constants and name table for the option acknowledgement checker.
`default_nettype none
package toc_pkg;

  // Option bit positions in option masks
  localparam int OPT_BLKSIZE = 0;
  localparam int OPT_WINDOW  = 1;
  localparam int OPT_TSIZE   = 2;
  localparam int OPT_COUNT   = 3;

  // Opcode bytes of an option acknowledgement
  localparam logic [7:0] HDR_BYTE0 = 8'h00;
  localparam logic [7:0] HDR_BYTE1 = 8'h06;

  // Option names (lower case) and their lengths
  localparam logic [8*7-1:0]  NAME_BLKSIZE = "blksize";
  localparam logic [8*10-1:0] NAME_WINDOW  = "windowsize";
  localparam logic [8*5-1:0]  NAME_TSIZE   = "tsize";
  localparam logic [3:0] LEN_BLKSIZE = 4'd7;
  localparam logic [3:0] LEN_WINDOW  = 4'd10;
  localparam logic [3:0] LEN_TSIZE   = 4'd5;
  localparam logic [3:0] NAME_POS_MAX = 4'd15;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQ_OPTIONS = 3'd0,
    CFG_REQ_BLKSIZE = 3'd1,
    CFG_REQ_WINDOW  = 3'd2,
    CFG_MIN_BLKSIZE = 3'd3,
    CFG_DEF_BLKSIZE = 3'd4
  } cfg_idx_t;

  // Classified byte passed from the front end to the parser
  typedef struct packed {
    logic [7:0] lower;     // byte with A-Z folded to lower case
    logic       is_nul;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_last;
  } byte_tok_t;

  // Expected lower-case character of an option name; NUL past its end
  function automatic logic [7:0] opt_char(input logic [1:0] opt, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (opt)
      2'(OPT_BLKSIZE): if (pos < LEN_BLKSIZE) c = NAME_BLKSIZE[8*(LEN_BLKSIZE-4'd1-pos) +: 8];
      2'(OPT_WINDOW):  if (pos < LEN_WINDOW)  c = NAME_WINDOW[8*(LEN_WINDOW-4'd1-pos) +: 8];
      2'(OPT_TSIZE):   if (pos < LEN_TSIZE)   c = NAME_TSIZE[8*(LEN_TSIZE-4'd1-pos) +: 8];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/toc_channels.sv
// Handshake channel interfaces for packet bytes, verdicts and register writes.
`default_nettype none
interface toc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       is_last;
  modport source (output valid, output packet_byte, output is_last, input ready);
  modport sink   (input valid, input packet_byte, input is_last, output ready);
endinterface

interface toc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  acked_options;
  logic [15:0] acked_blksize;
  logic [15:0] acked_window;
  logic [63:0] acked_tsize;
  modport source (output valid, output accepted, output acked_options, output acked_blksize,
                  output acked_window, output acked_tsize, input ready);
  modport sink   (input valid, input accepted, input acked_options, input acked_blksize,
                  input acked_window, input acked_tsize, output ready);
endinterface

interface toc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/toc_front.sv
// Front end: takes packet bytes and classifies them into parser tokens.
`default_nettype none
module toc_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        packet_byte,
  input  wire logic              is_last,
  input  wire logic              q_full,
  output logic                   push,
  output toc_pkg::byte_tok_t     push_tok
);

  logic is_upper;

  // Take a transfer whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Fold case, flag NUL and digits
  assign is_upper = (packet_byte >= toc_pkg::CHAR_UP_A) && (packet_byte <= toc_pkg::CHAR_UP_Z);

  always_comb begin
    push_tok.lower    = is_upper ? (packet_byte + toc_pkg::CASE_GAP) : packet_byte;
    push_tok.is_nul   = (packet_byte == 8'h00);
    push_tok.is_digit = (packet_byte >= toc_pkg::CHAR_ZERO) &&
                        (packet_byte <= toc_pkg::CHAR_NINE);
    push_tok.digit    = 4'(packet_byte - toc_pkg::CHAR_ZERO);
    push_tok.is_last  = is_last;
  end

endmodule
`default_nettype wire

FILE: hdl/toc_queue.sv
// Short token queue between the front end and the parser.
`default_nettype none
module toc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire toc_pkg::byte_tok_t push_tok,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output toc_pkg::byte_tok_t      head_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  toc_pkg::byte_tok_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = slot_r[rd_ptr_r];

  // Token storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/toc_back.sv
// Parser: walks header, names and values, checks options, registers the verdict.
`default_nettype none
module toc_back #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // token queue head
  input  wire logic               tok_valid,
  input  wire toc_pkg::byte_tok_t tok,
  output logic                    pop,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  // verdict
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    accepted,
  output logic [2:0]              acked_options,
  output logic [15:0]             acked_blksize,
  output logic [15:0]             acked_window,
  output logic [63:0]             acked_tsize
);

  typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_VALUE} phase_t;

  // configuration
  logic [2:0]  req_opts_r;
  logic [15:0] req_blk_r, req_win_r, min_blk_r, def_blk_r;

  // packet state
  phase_t                phase_r, phase_nxt;
  logic [1:0]            hc_r, hc_nxt;
  logic [3:0]            pos_r, pos_nxt;
  logic [2:0]            flags_r, flags_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  nonempty_r, nonempty_nxt;
  logic                  failed_r, failed_nxt;
  logic [2:0]            seen_r, seen_nxt;
  logic [15:0]           held_blk_r, held_blk_nxt;
  logic [15:0]           held_win_r, held_win_nxt;
  logic [VALUE_BITS-1:0] held_tsize_r, held_tsize_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        acc_ok_r, acc_ok_nxt;
  logic [2:0]  res_opts_r, res_opts_nxt;
  logic [15:0] res_blk_r, res_blk_nxt;
  logic [15:0] res_win_r, res_win_nxt;
  logic [63:0] res_tsize_r, res_tsize_nxt;

  // value datapath
  logic [VALUE_BITS+3:0] prod;
  logic                  overflow;
  logic [63:0]           acc64;
  logic                  hi_nz;
  logic                  blk_bad, win_bad;
  logic [2:0]            bad;
  logic                  fail, closed, ok;

  assign cfg_ready = 1'b1;

  // A last byte waits until the result register is free
  assign pop = tok_valid && (!tok.is_last || !out_valid_r || out_ready);

  // acc * 10 + digit, wide enough to see overflow
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (VALUE_BITS+4)'(tok.digit);
  assign overflow = |prod[VALUE_BITS+3:VALUE_BITS];

  // Range checks of a finished value
  assign acc64   = 64'(acc_r);
  assign hi_nz   = |acc64[63:16];
  assign blk_bad = hi_nz || (acc64[15:0] < min_blk_r) || (acc64[15:0] > req_blk_r);
  assign win_bad = hi_nz || (acc64[15:0] == 16'd0) || (acc64[15:0] > req_win_r);
  assign bad     = seen_r | ~req_opts_r;

  // Parser next state
  always_comb begin
    phase_nxt      = phase_r;
    hc_nxt         = hc_r;
    pos_nxt        = pos_r;
    flags_nxt      = flags_r;
    acc_nxt        = acc_r;
    nonempty_nxt   = nonempty_r;
    failed_nxt     = failed_r;
    seen_nxt       = seen_r;
    held_blk_nxt   = held_blk_r;
    held_win_nxt   = held_win_r;
    held_tsize_nxt = held_tsize_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    acc_ok_nxt     = acc_ok_r;
    res_opts_nxt   = res_opts_r;
    res_blk_nxt    = res_blk_r;
    res_win_nxt    = res_win_r;
    res_tsize_nxt  = res_tsize_r;
    fail           = 1'b0;
    closed         = 1'b0;
    ok             = 1'b0;

    if (pop && !failed_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (tok.is_last ||
              tok.lower != ((hc_r == 2'd0) ? toc_pkg::HDR_BYTE0 : toc_pkg::HDR_BYTE1)) begin
            fail = 1'b1;
          end else begin
            hc_nxt = hc_r + 2'd1;
            if (hc_r == 2'd1) begin
              phase_nxt = PH_NAME;
              pos_nxt   = '0;
              flags_nxt = 3'b111;
            end
          end
        end
        PH_NAME: begin
          if (tok.is_nul) begin
            if (pos_r == 4'd0 || tok.is_last) begin
              fail = 1'b1;
            end else begin
              flags_nxt[toc_pkg::OPT_BLKSIZE] = flags_r[toc_pkg::OPT_BLKSIZE] &&
                                               (pos_r == toc_pkg::LEN_BLKSIZE);
              flags_nxt[toc_pkg::OPT_WINDOW]  = flags_r[toc_pkg::OPT_WINDOW] &&
                                               (pos_r == toc_pkg::LEN_WINDOW);
              flags_nxt[toc_pkg::OPT_TSIZE]   = flags_r[toc_pkg::OPT_TSIZE] &&
                                               (pos_r == toc_pkg::LEN_TSIZE);
              phase_nxt    = PH_VALUE;
              acc_nxt      = '0;
              nonempty_nxt = 1'b0;
            end
          end else begin
            for (int i = 0; i < toc_pkg::OPT_COUNT; i++) begin
              if (tok.lower != toc_pkg::opt_char(2'(i), pos_r)) begin
                flags_nxt[i] = 1'b0;
              end
            end
            if (pos_r != toc_pkg::NAME_POS_MAX) begin
              pos_nxt = pos_r + 4'd1;
            end
          end
        end
        PH_VALUE: begin
          if (tok.is_nul) begin
            if (!nonempty_r) begin
              fail = 1'b1;
            end else if (flags_r[toc_pkg::OPT_BLKSIZE]) begin
              if (bad[toc_pkg::OPT_BLKSIZE] || blk_bad) begin
                fail = 1'b1;
              end else begin
                held_blk_nxt = acc64[15:0];
                seen_nxt[toc_pkg::OPT_BLKSIZE] = 1'b1;
              end
            end else if (flags_r[toc_pkg::OPT_WINDOW]) begin
              if (bad[toc_pkg::OPT_WINDOW] || win_bad) begin
                fail = 1'b1;
              end else begin
                held_win_nxt = acc64[15:0];
                seen_nxt[toc_pkg::OPT_WINDOW] = 1'b1;
              end
            end else if (flags_r[toc_pkg::OPT_TSIZE]) begin
              if (bad[toc_pkg::OPT_TSIZE]) begin
                fail = 1'b1;
              end else begin
                held_tsize_nxt = acc_r;
                seen_nxt[toc_pkg::OPT_TSIZE] = 1'b1;
              end
            end else begin
              fail = 1'b1;
            end
            if (!fail) begin
              phase_nxt = PH_NAME;
              pos_nxt   = '0;
              flags_nxt = 3'b111;
              closed    = 1'b1;
            end
          end else if (!tok.is_digit || overflow) begin
            fail = 1'b1;
          end else begin
            acc_nxt      = prod[VALUE_BITS-1:0];
            nonempty_nxt = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase
      if (fail) begin
        failed_nxt = 1'b1;
      end
    end

    // Last byte: register the verdict and clear the packet state
    if (pop && tok.is_last) begin
      ok            = !failed_nxt && closed;
      out_valid_nxt = 1'b1;
      acc_ok_nxt    = ok;
      res_opts_nxt  = ok ? seen_nxt : 3'b000;
      res_blk_nxt   = (ok && seen_nxt[toc_pkg::OPT_BLKSIZE]) ? held_blk_nxt : def_blk_r;
      res_win_nxt   = (ok && seen_nxt[toc_pkg::OPT_WINDOW]) ? held_win_nxt : 16'd1;
      res_tsize_nxt = (ok && seen_nxt[toc_pkg::OPT_TSIZE]) ? 64'(held_tsize_nxt) : 64'd0;
      phase_nxt     = PH_HEADER;
      hc_nxt        = '0;
      pos_nxt       = '0;
      flags_nxt     = 3'b111;
      acc_nxt       = '0;
      nonempty_nxt  = 1'b0;
      failed_nxt    = 1'b0;
      seen_nxt      = '0;
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hc_r        <= '0;
      pos_r       <= '0;
      flags_r     <= 3'b111;
      acc_r       <= '0;
      nonempty_r  <= 1'b0;
      failed_r    <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hc_r        <= hc_nxt;
      pos_r       <= pos_nxt;
      flags_r     <= flags_nxt;
      acc_r       <= acc_nxt;
      nonempty_r  <= nonempty_nxt;
      failed_r    <= failed_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    held_blk_r   <= held_blk_nxt;
    held_win_r   <= held_win_nxt;
    held_tsize_r <= held_tsize_nxt;
    acc_ok_r     <= acc_ok_nxt;
    res_opts_r   <= res_opts_nxt;
    res_blk_r    <= res_blk_nxt;
    res_win_r    <= res_win_nxt;
    res_tsize_r  <= res_tsize_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_opts_r <= 3'd0;
      req_blk_r  <= 16'd512;
      req_win_r  <= 16'd1;
      min_blk_r  <= 16'd8;
      def_blk_r  <= 16'd512;
    end else if (cfg_valid) begin
      case (cfg_index)
        toc_pkg::CFG_REQ_OPTIONS: req_opts_r <= cfg_data[2:0];
        toc_pkg::CFG_REQ_BLKSIZE: req_blk_r  <= cfg_data;
        toc_pkg::CFG_REQ_WINDOW:  req_win_r  <= cfg_data;
        toc_pkg::CFG_MIN_BLKSIZE: min_blk_r  <= cfg_data;
        toc_pkg::CFG_DEF_BLKSIZE: def_blk_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign accepted      = acc_ok_r;
  assign acked_options = res_opts_r;
  assign acked_blksize = res_blk_r;
  assign acked_window  = res_win_r;
  assign acked_tsize   = res_tsize_r;

`ifndef NO_ASSERTIONS
  // The opcode counter never passes the second byte while in the header
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> hc_r < 2'd2)
    else $error("header count out of range");

  // After a name ends at most one option can still match
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VALUE |-> $onehot0(flags_r))
    else $error("several option names matched");

  // Taking a last byte always yields a verdict next cycle
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    pop && tok.is_last |=> out_valid_r)
    else $error("last byte gave no verdict");

  // An accepted verdict never reports an option that was not requested
  a_req_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && acc_ok_r |-> (res_opts_r & ~req_opts_r) == 3'b000)
    else $error("unrequested option acknowledged");
`endif

endmodule
`default_nettype wire

FILE: hdl/tftp_oack_option_checker_top.sv
// A last byte's token passes through the queue; its verdict is then held in the result register.
// Throughput: one packet byte per cycle while the queue has room; the parser takes one token a cycle.
// A last byte waits in the queue while the previous verdict is still untaken.
// Reset (rst_n low, synchronous): queue empty, parser in the opcode phase, config registers to defaults.
// Verdict: one result per packet, on its last byte; pass or fail plus acknowledged values.
`default_nettype none
module tftp_oack_option_checker_top #(
  parameter int VALUE_BITS  = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  toc_in_if.sink    in_bus,
  toc_out_if.source out_bus,
  toc_cfg_if.sink   cfg_bus
);

  toc_pkg::byte_tok_t push_tok, head_tok;
  logic push, q_full, pop, head_valid;

  // Byte classification
  toc_front u_front (
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .packet_byte (in_bus.packet_byte),
    .is_last     (in_bus.is_last),
    .q_full      (q_full),
    .push        (push),
    .push_tok    (push_tok)
  );

  // Decoupling queue
  toc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  // Option parser and verdict register
  toc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .tok_valid     (head_valid),
    .tok           (head_tok),
    .pop           (pop),
    .cfg_valid     (cfg_bus.valid),
    .cfg_ready     (cfg_bus.ready),
    .cfg_index     (cfg_bus.index),
    .cfg_data      (cfg_bus.data),
    .out_valid     (out_bus.valid),
    .out_ready     (out_bus.ready),
    .accepted      (out_bus.accepted),
    .acked_options (out_bus.acked_options),
    .acked_blksize (out_bus.acked_blksize),
    .acked_window  (out_bus.acked_window),
    .acked_tsize   (out_bus.acked_tsize)
  );

endmodule
`default_nettype wire
